// ----- rtl/core/rmq_pkg.sv -----
`default_nettype none

package rmq_pkg;

  localparam int unsigned ElemW = 18;
  localparam int unsigned NumW  = 19;

  localparam logic [ElemW-1:0] Q_MAX = 18'h1FFFF;
  localparam logic [ElemW-1:0] Q_MIN = 18'h20000;

  typedef enum logic [1:0] {
    CASE_TRACE = 2'd0,
    CASE_X     = 2'd1,
    CASE_Y     = 2'd2,
    CASE_Z     = 2'd3
  } case_t;

  // Three numerators, in w/x/y/z order of the components that are not the half root
  typedef struct packed {
    case_t                 sel;
    logic                  bad;
    logic [2:0][NumW-1:0]  num;
  } pl_t;

endpackage

`default_nettype wire

// ----- rtl/core/rotation_matrix_to_quaternion_unit.sv -----
// From start to out_valid: input register, RW square-root stages, divider input register,
//   NW divider stages, output register (RW, NW: square-root and divider stage counts).
// Throughput: one matrix per cycle; busy stays low, the pipeline never stalls.
// The digit-per-stage square root and the three bit-per-stage dividers set the depth.
// Reset (rst_n low, synchronous) clears all stage valid bits; items in flight are dropped.
`default_nettype none

module rotation_matrix_to_quaternion_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [17:0] in_m00,
  input  wire logic [17:0] in_m01,
  input  wire logic [17:0] in_m02,
  input  wire logic [17:0] in_m10,
  input  wire logic [17:0] in_m11,
  input  wire logic [17:0] in_m12,
  input  wire logic [17:0] in_m20,
  input  wire logic [17:0] in_m21,
  input  wire logic [17:0] in_m22,
  output logic             out_valid,
  output logic [17:0]      out_qw,
  output logic [17:0]      out_qx,
  output logic [17:0]      out_qy,
  output logic [17:0]      out_qz,
  output logic [1:0]       out_case_taken,
  output logic             out_bad_input
);

  localparam int unsigned AW   = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 2;
  localparam int unsigned AS   = AW + 1;
  localparam int unsigned RADW = AW + FRAC_BITS;
  localparam int unsigned RW   = (RADW + 1) / 2;
  localparam int unsigned RAD2 = 2 * RW;
  localparam int unsigned RMW  = RW + 3;
  localparam int unsigned DW   = RW + 1;
  localparam int unsigned NW   = rmq_pkg::NumW + FRAC_BITS + 1;
  localparam int unsigned LAT  = RW + NW + 3;

  localparam logic signed [AS-1:0] ONE = AS'(1) << FRAC_BITS;

  function automatic logic [17:0] sat_q(logic [NW-1:0] mag, logic neg);
    logic [17:0] res;
    if (!neg) begin
      res = (mag > NW'(131071)) ? rmq_pkg::Q_MAX : mag[17:0];
    end else begin
      res = (mag > NW'(131072)) ? rmq_pkg::Q_MIN : (~mag[17:0] + 18'd1);
    end
    return res;
  endfunction

  assign busy = 1'b0;

  // ---------------- input stage: case choice, root argument, numerators
  logic signed [AS-1:0] a00, a11, a22, trace, arg_nxt;
  logic signed [18:0]   d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
  rmq_pkg::pl_t         pl_nxt;

  always_comb begin
    a00    = AS'($signed(in_m00));
    a11    = AS'($signed(in_m11));
    a22    = AS'($signed(in_m22));
    trace  = a00 + a11 + a22;
    d21_12 = 19'($signed(in_m21)) - 19'($signed(in_m12));
    d02_20 = 19'($signed(in_m02)) - 19'($signed(in_m20));
    d10_01 = 19'($signed(in_m10)) - 19'($signed(in_m01));
    s01_10 = 19'($signed(in_m01)) + 19'($signed(in_m10));
    s02_20 = 19'($signed(in_m02)) + 19'($signed(in_m20));
    s12_21 = 19'($signed(in_m12)) + 19'($signed(in_m21));
    if (trace >= 0) begin
      pl_nxt.sel = rmq_pkg::CASE_TRACE;
      arg_nxt    = trace + ONE;
      pl_nxt.num = {d10_01, d02_20, d21_12};
    end else if (a00 > a11 && a00 > a22) begin
      pl_nxt.sel = rmq_pkg::CASE_X;
      arg_nxt    = ONE + a00 - a11 - a22;
      pl_nxt.num = {s02_20, s01_10, d21_12};
    end else if (a11 > a22) begin
      pl_nxt.sel = rmq_pkg::CASE_Y;
      arg_nxt    = ONE + a11 - a00 - a22;
      pl_nxt.num = {s12_21, s01_10, d02_20};
    end else begin
      pl_nxt.sel = rmq_pkg::CASE_Z;
      arg_nxt    = ONE + a22 - a00 - a11;
      pl_nxt.num = {s12_21, s02_20, d10_01};
    end
    pl_nxt.bad = (arg_nxt <= 0);
  end

  // ---------------- square root, one result bit per stage
  logic                sq_v_r    [0:RW];
  logic [RMW-1:0]      sq_rem_r  [0:RW];
  logic [RW-1:0]       sq_root_r [0:RW];
  logic [RAD2-1:0]     sq_rad_r  [0:RW];
  rmq_pkg::pl_t        sq_pl_r   [0:RW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else begin
      sq_v_r[0] <= start && !busy;
    end
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
    sq_rad_r[0]  <= RAD2'({arg_nxt[AW-1:0], {FRAC_BITS{1'b0}}});
    sq_pl_r[0]   <= pl_nxt;
  end

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    logic [RMW-1:0] sq_tmp, sq_trial, sq_rem_nxt;
    logic           sq_ge;

    always_comb begin
      sq_tmp     = {sq_rem_r[i][RMW-3:0], sq_rad_r[i][RAD2-1 -: 2]};
      sq_trial   = {1'b0, sq_root_r[i], 2'b01};
      sq_ge      = (sq_tmp >= sq_trial);
      sq_rem_nxt = sq_ge ? (sq_tmp - sq_trial) : sq_tmp;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[i+1] <= 1'b0;
      end else begin
        sq_v_r[i+1] <= sq_v_r[i];
      end
      sq_rem_r[i+1]  <= sq_rem_nxt;
      sq_root_r[i+1] <= {sq_root_r[i][RW-2:0], sq_ge};
      sq_rad_r[i+1]  <= sq_rad_r[i] << 2;
      sq_pl_r[i+1]   <= sq_pl_r[i];
    end
  end

  // ---------------- dividers: three in parallel, one quotient bit per stage
  logic               dv_v_r    [0:NW];
  logic [DW-1:0]      dv_rem_r  [0:NW][0:2];
  logic [NW-1:0]      dv_nq_r   [0:NW][0:2];
  logic [DW-1:0]      dv_d_r    [0:NW];
  logic [RW-1:0]      dv_half_r [0:NW];
  logic [2:0]         dv_neg_r  [0:NW];
  rmq_pkg::case_t     dv_sel_r  [0:NW];
  logic               dv_bad_r  [0:NW];

  logic [RW-1:0]      root_fin;
  logic [RW:0]        root_inc;
  logic [18:0]        mag_nxt [0:2];
  logic [NW-1:0]      num_nxt [0:2];

  always_comb begin
    root_fin = sq_root_r[RW];
    root_inc = (RW+1)'(root_fin) + (RW+1)'(1);
    for (int k = 0; k < 3; k++) begin
      mag_nxt[k] = sq_pl_r[RW].num[k][18] ? (~sq_pl_r[RW].num[k] + 19'd1)
                                          : sq_pl_r[RW].num[k];
      // numerator carries the rounding term d/2 = root
      num_nxt[k] = (NW'(mag_nxt[k]) << FRAC_BITS) + NW'(root_fin);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else begin
      dv_v_r[0] <= sq_v_r[RW];
    end
    for (int k = 0; k < 3; k++) begin
      dv_rem_r[0][k] <= '0;
      dv_nq_r[0][k]  <= num_nxt[k];
      dv_neg_r[0][k] <= sq_pl_r[RW].num[k][18];
    end
    dv_d_r[0]    <= {root_fin, 1'b0};
    dv_half_r[0] <= root_inc[RW:1];
    dv_sel_r[0]  <= sq_pl_r[RW].sel;
    dv_bad_r[0]  <= sq_pl_r[RW].bad;
  end

  for (genvar j = 0; j < NW; j++) begin : g_div
    logic [DW:0]   dv_tmp [0:2];
    logic          dv_ge  [0:2];
    logic [DW-1:0] dv_rem_nxt [0:2];
    logic [DW:0]   dv_diff [0:2];

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        dv_tmp[k]     = {dv_rem_r[j][k], dv_nq_r[j][k][NW-1]};
        dv_ge[k]      = (dv_tmp[k] >= {1'b0, dv_d_r[j]});
        dv_diff[k]    = dv_tmp[k] - {1'b0, dv_d_r[j]};
        dv_rem_nxt[k] = dv_ge[k] ? dv_diff[k][DW-1:0] : dv_tmp[k][DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
      for (int k = 0; k < 3; k++) begin
        dv_rem_r[j+1][k] <= dv_rem_nxt[k];
        dv_nq_r[j+1][k]  <= {dv_nq_r[j][k][NW-2:0], dv_ge[k]};
      end
      dv_d_r[j+1]    <= dv_d_r[j];
      dv_half_r[j+1] <= dv_half_r[j];
      dv_neg_r[j+1]  <= dv_neg_r[j];
      dv_sel_r[j+1]  <= dv_sel_r[j];
      dv_bad_r[j+1]  <= dv_bad_r[j];
    end
  end

  // ---------------- output stage: saturate, place the half root, zero on bad input
  logic [17:0] q0, q1, q2, qh;
  logic [17:0] qw_nxt, qx_nxt, qy_nxt, qz_nxt;
  logic        out_valid_r, bad_r;
  logic [17:0] qw_r, qx_r, qy_r, qz_r;
  logic [1:0]  case_r;

  always_comb begin
    q0 = sat_q(dv_nq_r[NW][0], dv_neg_r[NW][0]);
    q1 = sat_q(dv_nq_r[NW][1], dv_neg_r[NW][1]);
    q2 = sat_q(dv_nq_r[NW][2], dv_neg_r[NW][2]);
    qh = sat_q(NW'(dv_half_r[NW]), 1'b0);
    qw_nxt = q0;
    qx_nxt = q1;
    qy_nxt = q2;
    qz_nxt = q2;
    case (dv_sel_r[NW])
      rmq_pkg::CASE_TRACE: begin
        qw_nxt = qh; qx_nxt = q0; qy_nxt = q1; qz_nxt = q2;
      end
      rmq_pkg::CASE_X: begin
        qw_nxt = q0; qx_nxt = qh; qy_nxt = q1; qz_nxt = q2;
      end
      rmq_pkg::CASE_Y: begin
        qw_nxt = q0; qx_nxt = q1; qy_nxt = qh; qz_nxt = q2;
      end
      rmq_pkg::CASE_Z: begin
        qw_nxt = q0; qx_nxt = q1; qy_nxt = q2; qz_nxt = qh;
      end
      default: begin
        qw_nxt = '0; qx_nxt = '0; qy_nxt = '0; qz_nxt = '0;
      end
    endcase
    if (dv_bad_r[NW]) begin
      qw_nxt = '0; qx_nxt = '0; qy_nxt = '0; qz_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_v_r[NW];
    end
    qw_r   <= qw_nxt;
    qx_r   <= qx_nxt;
    qy_r   <= qy_nxt;
    qz_r   <= qz_nxt;
    case_r <= dv_sel_r[NW];
    bad_r  <= dv_bad_r[NW];
  end

  assign out_valid      = out_valid_r;
  assign out_qw         = qw_r;
  assign out_qx         = qx_r;
  assign out_qy         = qy_r;
  assign out_qz         = qz_r;
  assign out_case_taken = case_r;
  assign out_bad_input  = bad_r;

  // ---------------- assertions
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LAT out_valid)
    else $error("transfer did not reach the output after the pipeline latency");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_input |->
      out_qw == '0 && out_qx == '0 && out_qy == '0 && out_qz == '0)
    else $error("bad input result carries nonzero quaternion");

  a_trace_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_case_taken == rmq_pkg::CASE_TRACE |-> !out_bad_input)
    else $error("trace branch flagged bad input");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int FracBits = 16;
  localparam int Latency = 58;
  localparam int CycleLimit = 400000;

  typedef struct {
    logic signed [17:0] m[9];
  } matrix_t;

  typedef struct {
    logic [17:0] qw, qx, qy, qz;
    rmq_pkg::case_t sel;
    logic        bad;
  } quat_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [17:0] in_m00 = '0, in_m01 = '0, in_m02 = '0, in_m10 = '0, in_m11 = '0;
  logic [17:0] in_m12 = '0, in_m20 = '0, in_m21 = '0, in_m22 = '0;
  logic out_valid;
  logic [17:0] out_qw, out_qx, out_qy, out_qz;
  logic [1:0] out_case_taken;
  logic out_bad_input;

  quat_t expected_quats[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;

  rotation_matrix_to_quaternion_unit #(.FRAC_BITS(FracBits)) dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0, bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // round(num / den) in the fixed-point format, ties away from zero
  function automatic longint fix_div(longint num, longint den);
    longint unsigned a, q;
    a = (num < 0) ? -num : num;
    a <<= FracBits;
    q = (a + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [17:0] clamp18(longint v);
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return v[17:0];
  endfunction

  function automatic quat_t matrix_to_quat(matrix_t mx);
    longint e[9];
    longint one = longint'(1) << FracBits;
    longint tr, arg, r, den, half, w, x, y, z;
    quat_t q;
    for (int i = 0; i < 9; i++) e[i] = mx.m[i];
    w = 0; x = 0; y = 0; z = 0;
    tr = e[0] + e[4] + e[8];
    if (tr >= 0) begin
      q.sel = rmq_pkg::CASE_TRACE; arg = tr + one;
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      q.sel = rmq_pkg::CASE_X; arg = one + e[0] - e[4] - e[8];
    end else if (e[4] > e[8]) begin
      q.sel = rmq_pkg::CASE_Y; arg = one + e[4] - e[0] - e[8];
    end else begin
      q.sel = rmq_pkg::CASE_Z; arg = one + e[8] - e[0] - e[4];
    end
    q.bad = (arg <= 0);
    if (!q.bad) begin
      r = int_sqrt(longint'(arg) << FracBits);
      den = 2 * r;
      half = (r + 1) >>> 1;
      case (q.sel)
        rmq_pkg::CASE_TRACE: begin
          w = half; x = fix_div(e[7] - e[5], den);
          y = fix_div(e[2] - e[6], den); z = fix_div(e[3] - e[1], den);
        end
        rmq_pkg::CASE_X: begin
          w = fix_div(e[7] - e[5], den); x = half;
          y = fix_div(e[1] + e[3], den); z = fix_div(e[2] + e[6], den);
        end
        rmq_pkg::CASE_Y: begin
          w = fix_div(e[2] - e[6], den); x = fix_div(e[1] + e[3], den);
          y = half; z = fix_div(e[5] + e[7], den);
        end
        default: begin
          w = fix_div(e[3] - e[1], den); x = fix_div(e[2] + e[6], den);
          y = fix_div(e[5] + e[7], den); z = half;
        end
      endcase
    end
    q.qw = clamp18(w); q.qx = clamp18(x); q.qy = clamp18(y); q.qz = clamp18(z);
    return q;
  endfunction

  // hold start high across back-to-back transfers; drop it only while idling
  task automatic send_matrix(matrix_t mx);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    {in_m00, in_m01, in_m02, in_m10, in_m11} <= {mx.m[0], mx.m[1], mx.m[2], mx.m[3], mx.m[4]};
    {in_m12, in_m20, in_m21, in_m22} <= {mx.m[5], mx.m[6], mx.m[7], mx.m[8]};
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_quats.push_back(matrix_to_quat(mx));
  endtask

  task automatic stop_sending();
    start <= 0;
  endtask

  always @(posedge clk) begin
    quat_t exp_q;
    if (rst_n && out_valid) begin
      if (expected_quats.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        exp_q = expected_quats.pop_front();
        if (out_qw !== exp_q.qw) begin
          $error("qw exp %h got %h", exp_q.qw, out_qw); errors++;
        end
        if (out_qx !== exp_q.qx) begin
          $error("qx exp %h got %h", exp_q.qx, out_qx); errors++;
        end
        if (out_qy !== exp_q.qy) begin
          $error("qy exp %h got %h", exp_q.qy, out_qy); errors++;
        end
        if (out_qz !== exp_q.qz) begin
          $error("qz exp %h got %h", exp_q.qz, out_qz); errors++;
        end
        if (out_case_taken !== exp_q.sel) begin
          $error("case_taken exp %0d got %0d", exp_q.sel, out_case_taken); errors++;
        end
        if (out_bad_input !== exp_q.bad) begin
          $error("bad_input exp %0d got %0d", exp_q.bad, out_bad_input); errors++;
        end
      end
    end
  end

  function automatic matrix_t fill_matrix(logic signed [17:0] v);
    matrix_t mx;
    for (int i = 0; i < 9; i++) mx.m[i] = v;
    return mx;
  endfunction

  // mostly moderate entries, now and then full-range ones
  function automatic matrix_t random_matrix();
    matrix_t mx;
    int pick = $urandom_range(9);
    for (int i = 0; i < 9; i++) begin
      if (pick < 3) mx.m[i] = 18'($urandom);
      else mx.m[i] = 18'($signed($urandom_range(131072)) - 65536);
    end
    return mx;
  endfunction

  task automatic test_directed();
    matrix_t mx;
    mx = fill_matrix(0);
    mx.m[0] = 65536; mx.m[4] = 65536; mx.m[8] = 65536;
    send_matrix(mx);
    send_matrix(fill_matrix(18'sh1FFFF));
    send_matrix(fill_matrix(18'sh20000));
    send_matrix(fill_matrix(0));
    send_matrix(fill_matrix(-1));
    // each diagonal largest with negative trace
    for (int k = 0; k < 3; k++) begin
      mx = fill_matrix(0);
      mx.m[0] = -65536; mx.m[4] = -65536; mx.m[8] = -65536;
      mx.m[k * 4] = 65536;
      mx.m[1] = 1000; mx.m[3] = -3000; mx.m[5] = 18'sh1FFFF; mx.m[7] = 18'sh20000;
      send_matrix(mx);
    end
    // ties on the diagonal fall through to later cases
    mx = fill_matrix(5);
    mx.m[0] = -100; mx.m[4] = -100; mx.m[8] = -200;
    send_matrix(mx);
    // full-scale diagonal entries of opposite sign
    mx = fill_matrix(7);
    mx.m[0] = -10; mx.m[4] = 18'sh20000; mx.m[8] = 18'sh1FFFF;
    send_matrix(mx);
    mx = fill_matrix(0);
    mx.m[0] = -131072; mx.m[4] = 131071; mx.m[8] = -1;
    send_matrix(mx);
    // full-scale off-diagonal entries, y diagonal largest
    mx = fill_matrix(18'sh1FFFF);
    mx.m[0] = 0; mx.m[4] = 0; mx.m[8] = -65536; mx.m[5] = 18'sh20000;
    send_matrix(mx);
    // negative trace with the y diagonal largest
    mx = fill_matrix(1);
    mx.m[0] = -65536; mx.m[4] = 0; mx.m[8] = -1;
    send_matrix(mx);
  endtask

  task automatic test_random(int n, int pct);
    send_idle_pct = pct;
    for (int i = 0; i < n; i++) send_matrix(random_matrix());
  endtask

  task automatic test_drain_pause();
    stop_sending();
    while (expected_quats.size() != 0) @(posedge clk);
    send_matrix(random_matrix());
  endtask

  initial begin
    int wait_cycles;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random(320, 33);
    test_drain_pause();
    test_random(320, 77);
    test_random(300, 0);
    stop_sending();
    wait_cycles = 0;
    while (expected_quats.size() != 0 && wait_cycles < 10 * Latency) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (Latency + 5) @(posedge clk);
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
